### design/tdma_pkg.sv
// Shared types and constants for the TDMA slot scheduler.
// Holds the item structs, action and event codes and the divider interface.
// No dependencies.
`default_nettype none

package tdma_pkg;

  localparam int unsigned CalSamplesDef = 16;
  localparam int unsigned DivNumW = 44;
  localparam int unsigned DivDenW = 25;
  localparam int unsigned CfgW = 25;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_GPS   = 3'd1,
    ACT_START = 3'd2,
    ACT_GOOD  = 3'd3,
    ACT_BAD   = 3'd4,
    ACT_BREAK = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    EV_TRANSMIT     = 4'd0,
    EV_MISSED_TX    = 4'd1,
    EV_NO_RECEIPT   = 4'd2,
    EV_RECEIPT      = 4'd3,
    EV_SLOT_TAKEN   = 4'd4,
    EV_OUT_OF_BOUND = 4'd5,
    EV_CALIBRATED   = 4'd6,
    EV_SAMPLE_TAKEN = 4'd7,
    EV_SAMPLE_REFUS = 4'd8,
    EV_WRONG_STATE  = 4'd9
  } event_e;

  typedef enum logic [2:0] {
    REG_RX_PERIOD  = 3'd0,
    REG_RX_OFFSET  = 3'd1,
    REG_TX_PERIOD  = 3'd2,
    REG_TX_OFFSET  = 3'd3,
    REG_RX_EXT     = 3'd4,
    REG_MAX_RX_ERR = 3'd5,
    REG_TX_WINDOW  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] local_time;
    logic signed [31:0] gps_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         event_res;
    logic signed [31:0] slot;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic                      done;
    logic signed [DivNumW-1:0] quo;
    logic [DivDenW-1:0]        rem;
  } div_res_t;

endpackage

`default_nettype wire

### design/tdma_div.sv
// Serial signed floor divider, one quotient bit per cycle.
// Gives floor quotient and a remainder in [0, den). Uses tdma_pkg.
`default_nettype none

module tdma_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [tdma_pkg::DivNumW-1:0] num_i,
  input  wire logic [tdma_pkg::DivDenW-1:0]        den_i,
  output tdma_pkg::div_res_t                       res_o
);
  import tdma_pkg::*;

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_e;

  dstate_e                   state_q;
  logic [CntW-1:0]           cnt_q;
  logic                      neg_q;
  logic [DivNumW-1:0]        mag_q;
  logic [DivDenW-1:0]        rem_q;
  logic [DivDenW-1:0]        den_q;
  logic                      done_q;
  logic signed [DivNumW-1:0] quo_q;
  logic [DivDenW-1:0]        remo_q;

  logic [DivDenW:0]   trial;
  logic               fits;
  logic [DivDenW-1:0] rem_next;

  assign trial    = {rem_q, mag_q[DivNumW-1]};
  assign fits     = trial >= {1'b0, den_q};
  assign rem_next = fits ? DivDenW'(trial - {1'b0, den_q}) : DivDenW'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= (state_q == D_FIX);
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            neg_q   <= num_i[DivNumW-1];
            mag_q   <= num_i[DivNumW-1] ? DivNumW'(-num_i) : DivNumW'(num_i);
            den_q   <= den_i;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= rem_next;
          mag_q <= {mag_q[DivNumW-2:0], fits};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DivNumW - 1)) begin
            state_q <= D_FIX;
          end
        end
        D_FIX: begin
          // Truncated magnitude result turned into floor division.
          if (neg_q && rem_q != '0) begin
            quo_q  <= $signed(~mag_q);
            remo_q <= den_q - rem_q;
          end else if (neg_q) begin
            quo_q  <= -$signed(mag_q);
            remo_q <= '0;
          end else begin
            quo_q  <= $signed(mag_q);
            remo_q <= rem_q;
          end
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign res_o.done = done_q;
  assign res_o.quo  = quo_q;
  assign res_o.rem  = remo_q;

endmodule

`default_nettype wire

### design/tdma_slot_scheduler.sv
// Top level of the TDMA slot scheduler: mode control, calibration and slot checks.
// Depends on tdma_pkg and the serial divider tdma_div.
//
//   channel | direction | handshake         | payload
//   in      | in        | in_valid/in_ready | in_item_i  (action, local_time, gps_time)
//   out     | out       | out_valid/ready   | out_item_o (event_res, slot, last)
//   cfg     | in        | cfg_we_i          | cfg_idx_i, cfg_data_i
//
// A tick in ready mode takes two serial divisions; a taken GPS sample, a reception outcome
// or a receive timeout check takes one division. Other items, and ticks while calibrating,
// exiting calibration or after a break, need no division.
// Results go through a single output register; a stalled output holds the sequencer.
// Reset is asynchronous and returns the scheduler to calibrating mode.
`default_nettype none

module tdma_slot_scheduler #(
  parameter int unsigned CAL_SAMPLES = tdma_pkg::CalSamplesDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire tdma_pkg::in_item_t             in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output tdma_pkg::out_item_t                 out_item_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [2:0]                     cfg_idx_i,
  input  wire logic [tdma_pkg::CfgW-1:0]      cfg_data_i
);
  import tdma_pkg::*;

  localparam int unsigned CntW = $clog2(CAL_SAMPLES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_TX, S_DIV_RX, S_DIV_OUTCOME, S_DIV_TIMEOUT, S_DIV_CAL, S_OUT
  } state_e;

  typedef enum logic [1:0] {M_CAL, M_EXIT, M_READY, M_RECV} mode_e;

  // Configuration registers.
  logic [23:0]        rx_period_q, tx_period_q, rx_ext_q, max_err_q, tx_win_q;
  logic signed [24:0] rx_off_q, tx_off_q;

  // Scheduler state.
  state_e             state_q;
  mode_e              mode_q;
  logic signed [39:0] err_sum_q;
  logic [CntW-1:0]    cnt_q;
  logic signed [31:0] clk_off_q;
  logic [1:0]         exit_q;
  logic signed [31:0] prev_q, oldp_q, t_q;
  logic signed [31:0] last_tx_q, last_rx_q, rx_start_q;
  logic               f_start_q, f_good_q, f_bad_q, f_break_q;
  event_e             ok_ev_q;
  logic signed [31:0] ts_q;
  logic [DivDenW-1:0] tx_rem_q;

  // Pending results and output register.
  event_e             res_ev_q [2];
  logic signed [31:0] res_slot_q [2];
  logic               nres_two_q, idx_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // Divider control.
  logic                      div_go_q;
  logic signed [DivNumW-1:0] div_num_q;
  logic [DivDenW-1:0]        div_den_q;
  div_res_t                  div_res;

  tdma_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .res_o   (div_res)
  );

  logic               accept;
  logic               div_go;
  logic signed [31:0] t_now;
  logic [23:0]        rp_eff, tp_eff;
  logic [CntW-1:0]    cnt_inc;
  logic signed [39:0] es_new;
  logic signed [31:0] q32, neg_slot;
  logic               tx_hit, tx_late, rx_hit;
  logic signed [34:0] tx_lim, to_diff;
  logic signed [25:0] err2;
  logic [25:0]        err_abs;
  logic               err_ok, to_hit;
  logic               out_free, out_load;

  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == S_OUT) && out_free;
  assign t_now    = in_item_i.local_time + clk_off_q;
  assign rp_eff   = (rx_period_q == '0) ? 24'd1 : rx_period_q;
  assign tp_eff   = (tx_period_q == '0) ? 24'd1 : tx_period_q;
  assign cnt_inc  = cnt_q + 1'b1;
  assign es_new   = err_sum_q + 40'(in_item_i.gps_time) - 40'(in_item_i.local_time);

  // A division starts on a ready tick, a receiving tick without a break, a GPS
  // sample that is still taken, and after the transmit slot division.
  assign div_go = (accept &&
                   (((in_item_i.action == ACT_TICK) &&
                     ((mode_q == M_READY) || ((mode_q == M_RECV) && !f_break_q))) ||
                    ((in_item_i.action == ACT_GPS) && (cnt_q < CntW'(CAL_SAMPLES)))))
                || ((state_q == S_DIV_TX) && div_res.done);

  assign q32      = $signed(div_res.quo[31:0]);
  assign neg_slot = -q32;

  // Transmit slot start is the old tick time minus the division remainder.
  assign tx_lim  = 35'(oldp_q) - $signed(35'(tx_rem_q)) + $signed(35'(tx_win_q));
  assign tx_late = 35'(t_q) > tx_lim;
  assign tx_hit  = ts_q > last_tx_q;
  assign rx_hit  = q32 > last_rx_q;

  // Distance to the nearest slot is half of (remainder - period).
  assign err2    = $signed(26'(div_res.rem)) - $signed(26'(rp_eff));
  assign err_abs = err2[25] ? 26'(-err2) : 26'(err2);
  assign err_ok  = err_abs[25:1] < 25'(max_err_q);

  assign to_diff = 35'(t_q) - 35'(rx_start_q) - $signed(35'(div_res.rem));
  assign to_hit  = to_diff > $signed(35'(rx_ext_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_period_q <= 24'd10000;
      tx_period_q <= 24'd10000;
      rx_off_q    <= '0;
      tx_off_q    <= '0;
      rx_ext_q    <= '0;
      max_err_q   <= '0;
      tx_win_q    <= 24'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RX_PERIOD:  rx_period_q <= cfg_data_i[23:0];
        REG_RX_OFFSET:  rx_off_q    <= $signed(cfg_data_i);
        REG_TX_PERIOD:  tx_period_q <= cfg_data_i[23:0];
        REG_TX_OFFSET:  tx_off_q    <= $signed(cfg_data_i);
        REG_RX_EXT:     rx_ext_q    <= cfg_data_i[23:0];
        REG_MAX_RX_ERR: max_err_q   <= cfg_data_i[23:0];
        REG_TX_WINDOW:  tx_win_q    <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_CAL;
      err_sum_q   <= '0;
      cnt_q       <= '0;
      clk_off_q   <= '0;
      exit_q      <= '0;
      prev_q      <= '0;
      last_tx_q   <= -32'sd1;
      last_rx_q   <= -32'sd1;
      rx_start_q  <= '0;
      f_start_q   <= 1'b0;
      f_good_q    <= 1'b0;
      f_bad_q     <= 1'b0;
      f_break_q   <= 1'b0;
      nres_two_q  <= 1'b0;
      idx_q       <= 1'b0;
      out_valid_q <= 1'b0;
      div_go_q    <= 1'b0;
    end else begin
      div_go_q    <= div_go;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            nres_two_q <= 1'b0;
            idx_q      <= 1'b0;
            case (in_item_i.action)
              ACT_TICK: begin
                t_q    <= t_now;
                oldp_q <= prev_q;
                prev_q <= t_now;
                unique case (mode_q)
                  M_CAL: begin
                    if (cnt_q >= CntW'(CAL_SAMPLES)) begin
                      mode_q <= M_EXIT;
                    end
                  end
                  M_EXIT: begin
                    if (exit_q == 2'd3) begin
                      mode_q        <= M_READY;
                      res_ev_q[0]   <= EV_CALIBRATED;
                      res_slot_q[0] <= '0;
                      state_q       <= S_OUT;
                    end else begin
                      exit_q <= exit_q + 1'b1;
                    end
                  end
                  M_READY: begin
                    div_num_q <= 44'(prev_q) - 44'(tx_off_q);
                    div_den_q <= DivDenW'(tp_eff);
                    state_q   <= S_DIV_TX;
                  end
                  M_RECV: begin
                    if (f_break_q) begin
                      f_break_q <= 1'b0;
                      mode_q    <= M_READY;
                    end else if (f_good_q || f_bad_q) begin
                      if (f_good_q) begin
                        f_good_q <= 1'b0;
                        ok_ev_q  <= EV_RECEIPT;
                      end else begin
                        f_bad_q <= 1'b0;
                        ok_ev_q <= EV_NO_RECEIPT;
                      end
                      // Nearest slot with ties down: ceil((2x - p) / 2p) = -floor((p - 2x) / 2p).
                      div_num_q <= $signed(44'(rp_eff))
                                 - ((44'(t_now) - 44'(rx_off_q)) <<< 1);
                      div_den_q <= DivDenW'(rp_eff) << 1;
                      state_q   <= S_DIV_OUTCOME;
                    end else begin
                      div_num_q <= 44'(rx_off_q) - 44'(rx_start_q);
                      div_den_q <= DivDenW'(rp_eff);
                      state_q   <= S_DIV_TIMEOUT;
                    end
                  end
                  default: ;
                endcase
              end
              ACT_GPS: begin
                if (cnt_q < CntW'(CAL_SAMPLES)) begin
                  err_sum_q <= es_new;
                  cnt_q     <= cnt_inc;
                  div_num_q <= (44'(es_new) <<< 1) + $signed(44'(cnt_inc));
                  div_den_q <= DivDenW'(cnt_inc) << 1;
                  state_q   <= S_DIV_CAL;
                end else begin
                  res_ev_q[0]   <= EV_SAMPLE_REFUS;
                  res_slot_q[0] <= '0;
                  state_q       <= S_OUT;
                end
              end
              ACT_START: begin
                f_start_q  <= 1'b1;
                rx_start_q <= t_now;
              end
              ACT_GOOD, ACT_BAD, ACT_BREAK: begin
                if (mode_q == M_RECV) begin
                  if (in_item_i.action == ACT_GOOD) begin
                    f_good_q <= 1'b1;
                  end else if (in_item_i.action == ACT_BAD) begin
                    f_bad_q <= 1'b1;
                  end else begin
                    f_break_q <= 1'b1;
                  end
                end else begin
                  res_ev_q[0]   <= EV_WRONG_STATE;
                  res_slot_q[0] <= '0;
                  state_q       <= S_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV_TX: begin
          if (div_res.done) begin
            ts_q      <= q32;
            tx_rem_q  <= div_res.rem;
            div_num_q <= 44'(t_q) - 44'(rx_off_q);
            div_den_q <= DivDenW'(rp_eff);
            state_q   <= S_DIV_RX;
          end
        end
        S_DIV_RX: begin
          if (div_res.done) begin
            if (tx_hit) begin
              res_ev_q[0]   <= tx_late ? EV_MISSED_TX : EV_TRANSMIT;
              res_slot_q[0] <= ts_q;
              last_tx_q     <= ts_q;
            end
            if (rx_hit) begin
              res_ev_q[tx_hit]   <= EV_NO_RECEIPT;
              res_slot_q[tx_hit] <= q32;
              last_rx_q          <= q32;
            end
            nres_two_q <= tx_hit && rx_hit;
            state_q    <= (tx_hit || rx_hit) ? S_OUT : S_IDLE;
            if (f_start_q) begin
              f_start_q <= 1'b0;
              mode_q    <= M_RECV;
            end
          end
        end
        S_DIV_OUTCOME: begin
          if (div_res.done) begin
            res_slot_q[0] <= neg_slot;
            if (neg_slot == last_rx_q) begin
              res_ev_q[0] <= EV_SLOT_TAKEN;
            end else if (err_ok) begin
              res_ev_q[0] <= ok_ev_q;
              last_rx_q   <= neg_slot;
            end else begin
              res_ev_q[0] <= EV_OUT_OF_BOUND;
            end
            mode_q  <= M_READY;
            state_q <= S_OUT;
          end
        end
        S_DIV_TIMEOUT: begin
          if (div_res.done) begin
            if (to_hit) begin
              res_slot_q[0] <= neg_slot;
              if (neg_slot == last_rx_q) begin
                res_ev_q[0] <= EV_SLOT_TAKEN;
              end else begin
                res_ev_q[0] <= EV_NO_RECEIPT;
                last_rx_q   <= neg_slot;
              end
              mode_q  <= M_READY;
              state_q <= S_OUT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_DIV_CAL: begin
          if (div_res.done) begin
            if (div_res.quo > 44'sd2147483647) begin
              clk_off_q <= 32'sh7fffffff;
            end else if (div_res.quo < -44'sd2147483648) begin
              clk_off_q <= 32'sh80000000;
            end else begin
              clk_off_q <= q32;
            end
            res_ev_q[0]   <= EV_SAMPLE_TAKEN;
            res_slot_q[0] <= '0;
            state_q       <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_q.event_res <= res_ev_q[idx_q];
            out_q.slot      <= res_slot_q[idx_q];
            out_q.last      <= (idx_q == nres_two_q);
            if (idx_q == nres_two_q) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

### test/tb_tdma_slot_scheduler.sv
// Self-checking testbench for the TDMA slot scheduler.
// Runs a directed table, then random phases, against an in-bench predictor.
// Depends on tdma_pkg and the design files.
`timescale 1ns / 100ps

module tb_tdma_slot_scheduler;
  import tdma_pkg::*;

  localparam int unsigned CalSamples = 16;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned ItemsPerPhase = 95;
  localparam int unsigned SettleCycles = 200;

  typedef enum logic [1:0] {MD_CAL, MD_EXIT, MD_READY, MD_RECV} sched_mode_e;
  localparam logic [3:0] FL_START = 4'd1;
  localparam logic [3:0] FL_GOOD  = 4'd2;
  localparam logic [3:0] FL_BAD   = 4'd4;
  localparam logic [3:0] FL_BREAK = 4'd8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tdma_slot_scheduler dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // Predictor state and configuration copy.
  longint rx_per, tx_per, rx_off, tx_off, rx_ext, max_err, tx_win;
  sched_mode_e md;
  longint err_sum, clk_off, prev_t, last_tx, last_rx, rx_start;
  int unsigned n_samples, exit_cnt;
  logic [3:0] flags;

  out_item_t step_events[$];
  out_item_t pending_events[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned hold_id = 0;
  int unsigned ev_hist [16];

  function automatic longint w32(longint x);
    return longint'($signed(x[31:0]));
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint ceil_div(longint a, longint b);
    return -floor_div(-a, b);
  endfunction

  function automatic longint eff_per(longint p);
    return (p == 0) ? 64'sd1 : p;
  endfunction

  task automatic add_event(event_e ev, longint slot);
    out_item_t r;
    r.event_res = ev;
    r.slot = slot[31:0];
    r.last = 1'b0;
    step_events.push_back(r);
  endtask

  task automatic match_outcome(longint t, event_e ok_ev);
    longint p, slot, s32, err;
    p = eff_per(rx_per);
    slot = ceil_div(2 * (t - rx_off) - p, 2 * p);
    s32 = w32(slot);
    if (s32 == last_rx) begin
      add_event(EV_SLOT_TAKEN, s32);
    end else begin
      err = slot * p + rx_off - t;
      if (err < 0) err = -err;
      if (err < max_err) begin
        add_event(ok_ev, s32);
        last_rx = s32;
      end else begin
        add_event(EV_OUT_OF_BOUND, s32);
      end
    end
    md = MD_READY;
  endtask

  task automatic sched_tick(longint t);
    longint tp, rp, ts, rs, tt, p, slot, et, s32;
    case (md)
      MD_CAL: begin
        if (n_samples >= CalSamples) md = MD_EXIT;
      end
      MD_EXIT: begin
        if (exit_cnt > 2) begin
          md = MD_READY;
          add_event(EV_CALIBRATED, 0);
        end
        if (exit_cnt < 3) exit_cnt++;
      end
      MD_READY: begin
        tp = eff_per(tx_per);
        rp = eff_per(rx_per);
        ts = floor_div(prev_t - tx_off, tp);
        rs = floor_div(t - rx_off, rp);
        if (w32(ts) > last_tx) begin
          tt = ts * tp + tx_off;
          add_event((t > tt + tx_win) ? EV_MISSED_TX : EV_TRANSMIT, w32(ts));
          last_tx = w32(ts);
        end
        if (w32(rs) > last_rx) begin
          last_rx = w32(rs);
          add_event(EV_NO_RECEIPT, last_rx);
        end
        if (flags & FL_START) begin
          flags &= ~FL_START;
          md = MD_RECV;
        end
      end
      default: begin
        if (flags & FL_BREAK) begin
          flags &= ~FL_BREAK;
          md = MD_READY;
        end else if (flags & FL_GOOD) begin
          flags &= ~FL_GOOD;
          match_outcome(t, EV_RECEIPT);
        end else if (flags & FL_BAD) begin
          flags &= ~FL_BAD;
          match_outcome(t, EV_NO_RECEIPT);
        end else begin
          p = eff_per(rx_per);
          slot = ceil_div(rx_start - rx_off, p);
          et = slot * p + rx_off;
          if (t - et > rx_ext) begin
            s32 = w32(slot);
            if (s32 == last_rx) begin
              add_event(EV_SLOT_TAKEN, s32);
            end else begin
              add_event(EV_NO_RECEIPT, s32);
              last_rx = s32;
            end
            md = MD_READY;
          end
        end
      end
    endcase
    prev_t = t;
  endtask

  // Works out the results of one accepted item into step_events.
  task automatic predict_item(in_item_t it);
    longint lt, gt, c, q;
    lt = longint'(it.local_time);
    gt = longint'(it.gps_time);
    step_events.delete();
    case (it.action)
      ACT_TICK: sched_tick(w32(lt + clk_off));
      ACT_GPS: begin
        if (n_samples < CalSamples) begin
          c = err_sum + (gt - lt);
          err_sum = longint'($signed(c[39:0]));
          n_samples++;
          c = longint'(n_samples);
          q = floor_div(2 * err_sum + c, 2 * c);
          if (q > 64'sd2147483647) q = 64'sd2147483647;
          if (q < -64'sd2147483648) q = -64'sd2147483648;
          clk_off = q;
          add_event(EV_SAMPLE_TAKEN, 0);
        end else begin
          add_event(EV_SAMPLE_REFUS, 0);
        end
      end
      ACT_START: begin
        flags |= FL_START;
        rx_start = w32(lt + clk_off);
      end
      ACT_GOOD, ACT_BAD, ACT_BREAK: begin
        if (md == MD_RECV)
          flags |= (it.action == ACT_GOOD) ? FL_GOOD :
                   (it.action == ACT_BAD) ? FL_BAD : FL_BREAK;
        else
          add_event(EV_WRONG_STATE, 0);
      end
      default: ;
    endcase
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
  endtask

  task automatic predictor_reset();
    rx_per = 10000; tx_per = 10000; rx_off = 0; tx_off = 0;
    rx_ext = 0; max_err = 0; tx_win = 200;
    md = MD_CAL; err_sum = 0; n_samples = 0; clk_off = 0; exit_cnt = 0;
    prev_t = 0; last_tx = -1; last_rx = -1; rx_start = 0; flags = '0;
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(reg_idx_e idx, longint value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[CfgW-1:0];
    @(posedge clk);
    case (idx)
      REG_RX_PERIOD:  rx_per  = longint'(value[23:0]);
      REG_RX_OFFSET:  rx_off  = longint'($signed(value[24:0]));
      REG_TX_PERIOD:  tx_per  = longint'(value[23:0]);
      REG_TX_OFFSET:  tx_off  = longint'($signed(value[24:0]));
      REG_RX_EXT:     rx_ext  = longint'(value[23:0]);
      REG_MAX_RX_ERR: max_err = longint'(value[23:0]);
      default:        tx_win  = longint'(value[23:0]);
    endcase
  endtask

  // Sender with bursts and gaps. Called at a rising edge; returns at the accepting edge.
  int unsigned burst_left = 0;
  task automatic send_item(in_item_t it, bit typed, event_e typed_ev);
    int unsigned gap;
    out_item_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_item(it);
    if (typed) begin
      r.event_res = typed_ev;
      r.slot = '0;
      r.last = 1'b1;
      pending_events.push_back(r);
    end else begin
      foreach (step_events[i]) pending_events.push_back(step_events[i]);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Receiver: random stall pattern, plus a long hold-off on request.
  int unsigned seen_hold = 0;
  int unsigned hold_cnt = 0;
  int unsigned run_cnt = 0;
  bit run_ready = 1'b1;
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (seen_hold != hold_id) begin
      seen_hold = hold_id;
      hold_cnt = 600;
      out_ready <= 1'b0;
    end else begin
      if (run_cnt == 0) begin
        run_ready = ($urandom_range(0, 2) != 0);
        run_cnt = run_ready ? $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12)
                            : $urandom_range(1, 8);
      end
      run_cnt--;
      out_ready <= run_ready;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      ev_hist[out_item.event_res]++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: event %0d slot %0d last %0b",
                   out_item.event_res, out_item.slot, out_item.last);
      end else begin
        exp_r = pending_events.pop_front();
        if (exp_r !== out_item) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected event %0d slot %0d last %0b, got %0d %0d %0b",
                     exp_r.event_res, exp_r.slot, exp_r.last,
                     out_item.event_res, out_item.slot, out_item.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d results outstanding", pending_events.size());
      $display("tb_tdma_slot_scheduler: FAIL");
      $finish;
    end
  end

  typedef struct {
    action_e act;
    int      lt;
    int      gt;
    bit      typed;
    event_e  ev;
  } dir_row_t;

  localparam int MaxI = 32'h7fffffff;
  localparam int MinI = 32'h80000000;

  dir_row_t dir_rows [$] = '{
    '{ACT_GOOD,  0, 0, 1'b1, EV_WRONG_STATE},
    '{ACT_BAD,   0, 0, 1'b1, EV_WRONG_STATE},
    '{ACT_BREAK, 0, 0, 1'b1, EV_WRONG_STATE},
    '{ACT_START, 100, 0, 1'b0, EV_TRANSMIT},
    '{ACT_TICK,  100, 0, 1'b0, EV_TRANSMIT},
    // Extreme differences first saturate the offset, then cancel out.
    '{ACT_GPS, MinI, MaxI, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, MinI, MaxI, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, MaxI, MinI, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, MaxI, MinI, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 0, -1, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 1, 0, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 10, 40, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 20, 50, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 30, 33, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 40, 41, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 50, 52, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 60, 61, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 70, 75, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 80, 80, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 90, 91, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 99, 100, 1'b1, EV_SAMPLE_TAKEN},
    '{ACT_GPS, 5, 5, 1'b1, EV_SAMPLE_REFUS},
    '{ACT_TICK, 200, 0, 1'b0, EV_TRANSMIT},
    '{ACT_TICK, 300, 0, 1'b0, EV_TRANSMIT},
    '{ACT_TICK, 400, 0, 1'b0, EV_TRANSMIT},
    '{ACT_TICK, 500, 0, 1'b0, EV_TRANSMIT},
    '{ACT_TICK, 600, 0, 1'b1, EV_CALIBRATED}
  };

  // Mostly well-formed traffic around a slowly advancing local clock.
  task automatic random_item(ref longint now, input longint step_max, output in_item_t it);
    int unsigned r;
    r = $urandom_range(0, 99);
    it.gps_time = $urandom;
    it.local_time = now[31:0];
    if (r < 55) begin
      now += $urandom_range(0, 32'(step_max));
      it.action = ACT_TICK;
      it.local_time = now[31:0];
    end else if (r < 60) begin
      it.action = ACT_GPS;
    end else if (r < 72) begin
      it.action = ACT_START;
      it.local_time = now[31:0] + $urandom_range(0, 32'(step_max));
    end else if (r < 81) begin
      it.action = ACT_GOOD;
    end else if (r < 88) begin
      it.action = ACT_BAD;
    end else if (r < 93) begin
      it.action = ACT_BREAK;
    end else if (r < 95) begin
      it.action = 3'($urandom_range(6, 7));
      it.local_time = $urandom;
    end else begin
      it.action = 3'($urandom_range(0, 2));
      it.local_time = $urandom;
    end
  endtask

  initial begin
    in_item_t it;
    longint now;
    longint step_max;
    predictor_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.action = dir_rows[i].act;
      it.local_time = dir_rows[i].lt;
      it.gps_time = dir_rows[i].gt;
      send_item(it, dir_rows[i].typed, dir_rows[i].ev);
    end

    now = 1000;
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_settle();
      case (ph)
        0: begin
          write_reg(REG_RX_PERIOD, 500);   write_reg(REG_RX_OFFSET, 0);
          write_reg(REG_TX_PERIOD, 700);   write_reg(REG_TX_OFFSET, 0);
          write_reg(REG_RX_EXT, 100);      write_reg(REG_MAX_RX_ERR, 200);
          write_reg(REG_TX_WINDOW, 50);
          step_max = 300;
        end
        1: begin
          // A zero period acts as one; new slots appear on nearly every tick.
          write_reg(REG_RX_PERIOD, 0);     write_reg(REG_RX_OFFSET, -16777216);
          write_reg(REG_TX_PERIOD, 1);     write_reg(REG_TX_OFFSET, 16777215);
          write_reg(REG_RX_EXT, 0);        write_reg(REG_MAX_RX_ERR, 0);
          write_reg(REG_TX_WINDOW, 0);
          step_max = 5;
        end
        2: begin
          write_reg(REG_RX_PERIOD, 16777215); write_reg(REG_RX_OFFSET, 16777215);
          write_reg(REG_TX_PERIOD, 16777215); write_reg(REG_TX_OFFSET, -16777216);
          write_reg(REG_RX_EXT, 16777215);    write_reg(REG_MAX_RX_ERR, 16777215);
          write_reg(REG_TX_WINDOW, 16777215);
          step_max = 8000000;
          hold_id++;
        end
        default: begin
          write_reg(REG_RX_PERIOD, $urandom_range(50, 2000));
          write_reg(REG_RX_OFFSET, longint'($urandom_range(0, 4000)) - 2000);
          write_reg(REG_TX_PERIOD, $urandom_range(50, 2000));
          write_reg(REG_TX_OFFSET, longint'($urandom_range(0, 4000)) - 2000);
          write_reg(REG_RX_EXT, $urandom_range(0, 500));
          write_reg(REG_MAX_RX_ERR, $urandom_range(0, 1000));
          write_reg(REG_TX_WINDOW, $urandom_range(0, 500));
          step_max = 600;
        end
      endcase
      cfg_we <= 1'b0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        random_item(now, step_max, it);
        send_item(it, 1'b0, EV_TRANSMIT);
      end
    end

    in_valid <= 1'b0;
    while (pending_events.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d items over four register settings; checked %0d results.",
             items_sent, results_seen);
    $display("Transmit %0d, missed %0d, no receipt %0d, receipt %0d, taken %0d, bounds %0d.",
             ev_hist[EV_TRANSMIT], ev_hist[EV_MISSED_TX], ev_hist[EV_NO_RECEIPT],
             ev_hist[EV_RECEIPT], ev_hist[EV_SLOT_TAKEN], ev_hist[EV_OUT_OF_BOUND]);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("tb_tdma_slot_scheduler: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_tdma_slot_scheduler: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/tdma_pkg.sv
design/tdma_div.sv
design/tdma_slot_scheduler.sv
test/tb_tdma_slot_scheduler.sv
